// ----- rtl/mis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_pkg
// shared constants, state and micro-operation codes, control structs
// ----------------------------------------------------------------------------
package mis_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int STORE_DEPTH  = 64;
    localparam int LVL_WORDS    = 128;
    localparam int LVL_DEPTH    = 8;
    localparam logic [8:0] CMP_MAX = 9'd511;

    typedef enum logic [5:0] {
        S_LOAD, S_INIT, S_FILL,
        S_DCHK, S_DRA, S_DRB, S_DKA, S_DKB, S_DCMP, S_DNXT,
        S_UINIT, S_UBASE, S_ULVL,
        S_PRD, S_PWR, S_CRD, S_CWR, S_SRD, S_SWR,
        S_HRB, S_HRP, S_HWR,
        S_JCHK, S_JSTEP, S_PRB, S_PHOLD, S_LRD, S_LCHK, S_ERD, S_EWR,
        S_ORD, S_OWR, S_KRD, S_KWR, S_BCHK, S_BRS, S_BCMP,
        S_SHCHK, S_SHWR, S_LDONE,
        S_ORC, S_ORS, S_OLD, S_OWAIT
    } state_t;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_FILL,
        OP_DCHK, OP_DRA, OP_DRB, OP_DKA, OP_DKB, OP_DCMP, OP_LINC,
        OP_UINIT, OP_UBASE, OP_ULVL,
        OP_PRD, OP_PWR, OP_CRD, OP_CWR, OP_SRD, OP_SWR,
        OP_HRB, OP_HRP, OP_HWR,
        OP_JMIN, OP_JADV, OP_PRB, OP_PHOLD, OP_LRD, OP_LCHK, OP_ERD, OP_EWR,
        OP_ORD, OP_OWR, OP_KRD, OP_KWR, OP_BMID, OP_BRS, OP_BCMP,
        OP_SINIT, OP_SRDK, OP_SHW, OP_INS, OP_LDEC,
        OP_OINIT, OP_ORC, OP_ORS, OP_OLD, OP_ONXT, OP_CLR
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic n_small;
        logic i_last_n;
        logic i_last_m;
        logic lvl_zero;
        logic prev_lt_pend;
        logic j_gt_prev;
        logic j_le_m;
        logic pos_hit;
        logic lo_lt_hi;
        logic k_gt_lo;
        logic out_last;
    } status_t;

endpackage

// ----- rtl/mis_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_ctrl
// sequencer for load, pairing descent, insertion ascent and result transfer
// ----------------------------------------------------------------------------
module mis_ctrl
    import mis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    final_item,
    output logic    item_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (final_item)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.op     = OP_FILL;
                state_next = sts.i_last_n ? S_DCHK : S_FILL;
            end
            S_DCHK:
            begin
                cmd.op     = OP_DCHK;
                state_next = sts.n_small ? S_UINIT : S_DRA;
            end
            S_DRA:
            begin
                cmd.op     = OP_DRA;
                state_next = S_DRB;
            end
            S_DRB:
            begin
                cmd.op     = OP_DRB;
                state_next = S_DKA;
            end
            S_DKA:
            begin
                cmd.op     = OP_DKA;
                state_next = S_DKB;
            end
            S_DKB:
            begin
                cmd.op     = OP_DKB;
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                cmd.op     = OP_DCMP;
                state_next = sts.i_last_m ? S_DNXT : S_DRA;
            end
            S_DNXT:
            begin
                cmd.op     = OP_LINC;
                state_next = S_DCHK;
            end
            S_UINIT:
            begin
                cmd.op     = OP_UINIT;
                state_next = S_UBASE;
            end
            S_UBASE:
            begin
                cmd.op     = OP_UBASE;
                state_next = S_LDONE;
            end
            S_ULVL:
            begin
                cmd.op     = OP_ULVL;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.op     = OP_PRD;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.op     = OP_PWR;
                state_next = sts.i_last_m ? S_CRD : S_PRD;
            end
            S_CRD:
            begin
                cmd.op     = OP_CRD;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                cmd.op     = OP_CWR;
                state_next = sts.i_last_m ? S_SRD : S_CRD;
            end
            S_SRD:
            begin
                cmd.op     = OP_SRD;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.op     = OP_SWR;
                state_next = sts.i_last_m ? S_HRB : S_SRD;
            end
            S_HRB:
            begin
                cmd.op     = OP_HRB;
                state_next = S_HRP;
            end
            S_HRP:
            begin
                cmd.op     = OP_HRP;
                state_next = S_HWR;
            end
            S_HWR:
            begin
                cmd.op     = OP_HWR;
                state_next = S_JCHK;
            end
            S_JCHK:
            begin
                cmd.op     = OP_JMIN;
                state_next = sts.prev_lt_pend ? S_JSTEP : S_LDONE;
            end
            S_JSTEP:
            begin
                if (sts.j_gt_prev)
                begin
                    state_next = sts.j_le_m ? S_PRB : S_ORD;
                end
                else
                begin
                    cmd.op     = OP_JADV;
                    state_next = S_JCHK;
                end
            end
            S_PRB:
            begin
                cmd.op     = OP_PRB;
                state_next = S_PHOLD;
            end
            S_PHOLD:
            begin
                cmd.op     = OP_PHOLD;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                cmd.op     = OP_LRD;
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                cmd.op     = OP_LCHK;
                state_next = sts.pos_hit ? S_ERD : S_LRD;
            end
            S_ERD:
            begin
                cmd.op     = OP_ERD;
                state_next = S_EWR;
            end
            S_EWR:
            begin
                cmd.op     = OP_EWR;
                state_next = S_KRD;
            end
            S_ORD:
            begin
                cmd.op     = OP_ORD;
                state_next = S_OWR;
            end
            S_OWR:
            begin
                cmd.op     = OP_OWR;
                state_next = S_KRD;
            end
            S_KRD:
            begin
                cmd.op     = OP_KRD;
                state_next = S_KWR;
            end
            S_KWR:
            begin
                cmd.op     = OP_KWR;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.op     = OP_BMID;
                    state_next = S_BRS;
                end
                else
                begin
                    cmd.op     = OP_SINIT;
                    state_next = S_SHCHK;
                end
            end
            S_BRS:
            begin
                cmd.op     = OP_BRS;
                state_next = S_BCMP;
            end
            S_BCMP:
            begin
                cmd.op     = OP_BCMP;
                state_next = S_BCHK;
            end
            S_SHCHK:
            begin
                if (sts.k_gt_lo)
                begin
                    cmd.op     = OP_SRDK;
                    state_next = S_SHWR;
                end
                else
                begin
                    cmd.op     = OP_INS;
                    state_next = S_JSTEP;
                end
            end
            S_SHWR:
            begin
                cmd.op     = OP_SHW;
                state_next = S_SHCHK;
            end
            S_LDONE:
            begin
                if (sts.lvl_zero)
                begin
                    cmd.op     = OP_OINIT;
                    state_next = S_ORC;
                end
                else
                begin
                    cmd.op     = OP_LDEC;
                    state_next = S_ULVL;
                end
            end
            S_ORC:
            begin
                cmd.op     = OP_ORC;
                state_next = S_ORS;
            end
            S_ORS:
            begin
                cmd.op     = OP_ORS;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.op     = OP_OLD;
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    if (sts.out_last)
                    begin
                        cmd.op     = OP_CLR;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.op     = OP_ONXT;
                        state_next = S_ORC;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/mis_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mis_dp
// element store, level lists, chain memories, index registers and comparator
// ----------------------------------------------------------------------------
module mis_dp
    import mis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            sts,
    input  logic signed [31:0] value,
    output logic signed [31:0] sorted_value,
    output logic [8:0]         comparisons,
    output logic               overflowed,
    output logic               last_result
);

    // memories
    logic [31:0] st_mem [STORE_DEPTH];
    logic [5:0]  lv_mem [LVL_WORDS];
    logic [5:0]  sm_mem [LVL_WORDS];
    logic [5:0]  pa_mem [STORE_DEPTH];
    logic [5:0]  ch_mem [STORE_DEPTH];
    logic [5:0]  bg_mem [STORE_DEPTH];

    logic        st_we, lv_we, sm_we, pa_we, ch_we, bg_we;
    logic [5:0]  st_wa, pa_wa, ch_wa, bg_wa;
    logic [6:0]  lv_wa;
    logic [31:0] st_wd;
    logic [5:0]  lv_wd, sm_wd, pa_wd, ch_wd, bg_wd;
    logic [5:0]  st_ra, pa_ra, ch_ra, bg_ra;
    logic [6:0]  lv_ra;
    logic [31:0] st_rd_reg;
    logic [5:0]  lv_rd_reg, sm_rd_reg, pa_rd_reg, ch_rd_reg, bg_rd_reg;

    // control counters
    logic [6:0] cnt_reg, cnt_next;
    logic [8:0] cmp_reg, cmp_next;
    logic       drop_reg, drop_next;

    // working registers
    logic [2:0]  lvl_reg, lvl_next;
    logic [6:0]  lv_n_reg [LVL_DEPTH];
    logic [6:0]  lv_n_next [LVL_DEPTH];
    logic [6:0]  lv_off_reg [LVL_DEPTH];
    logic [6:0]  lv_off_next [LVL_DEPTH];
    logic [6:0]  i_reg, i_next;
    logic [6:0]  m_reg, m_next;
    logic [6:0]  len_reg, len_next;
    logic [6:0]  pend_reg, pend_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  cur_reg, cur_next;
    logic [6:0]  j_reg, j_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  bound_reg, bound_next;
    logic [6:0]  lo_reg, lo_next;
    logic [6:0]  hi_reg, hi_next;
    logic [6:0]  mid_reg, mid_next;
    logic [6:0]  k_reg, k_next;
    logic [5:0]  a_reg, a_next;
    logic [5:0]  b_reg, b_next;
    logic [5:0]  psl_reg, psl_next;
    logic [5:0]  elem_reg, elem_next;
    logic [31:0] ka_reg, ka_next;
    logic [31:0] sv_reg, sv_next;
    logic [8:0]  cv_reg, cv_next;
    logic        ov_reg, ov_next;
    logic        last_reg, last_next;

    logic [2:0]  lvl_inc;
    logic [6:0]  cur_n, cur_off, nxt_n, nxt_off;
    logic [6:0]  mid_c;
    logic [6:0]  i_inc;
    logic [8:0]  cmp_inc;
    logic        b_lt_a, e_lt_c;

    assign lvl_inc = lvl_reg + 3'd1;
    assign cur_n   = lv_n_reg[lvl_reg];
    assign cur_off = lv_off_reg[lvl_reg];
    assign nxt_n   = lv_n_reg[lvl_inc];
    assign nxt_off = lv_off_reg[lvl_inc];
    assign mid_c   = 7'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign i_inc   = i_reg + 7'd1;
    assign cmp_inc = (cmp_reg != CMP_MAX) ? cmp_reg + 9'd1 : cmp_reg;
    assign b_lt_a  = $signed(st_rd_reg) < $signed(ka_reg);
    assign e_lt_c  = $signed(ka_reg) < $signed(st_rd_reg);

    always_comb
    begin
        sts.n_small      = cur_n < 7'd2;
        sts.i_last_n     = i_inc == cnt_reg;
        sts.i_last_m     = i_inc == m_reg;
        sts.lvl_zero     = lvl_reg == 3'd0;
        sts.prev_lt_pend = prev_reg < {1'b0, pend_reg};
        sts.j_gt_prev    = {1'b0, j_reg} > prev_reg;
        sts.j_le_m       = j_reg <= m_reg;
        sts.pos_hit      = ch_rd_reg == psl_reg;
        sts.lo_lt_hi     = lo_reg < hi_reg;
        sts.k_gt_lo      = k_reg > lo_reg;
        sts.out_last     = last_reg;
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        cmp_next    = cmp_reg;
        drop_next   = drop_reg;
        lvl_next    = lvl_reg;
        lv_n_next   = lv_n_reg;
        lv_off_next = lv_off_reg;
        i_next      = i_reg;
        m_next      = m_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        bound_next  = bound_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        psl_next    = psl_reg;
        elem_next   = elem_reg;
        ka_next     = ka_reg;
        sv_next     = sv_reg;
        cv_next     = cv_reg;
        ov_next     = ov_reg;
        last_next   = last_reg;

        st_we = 1'b0; st_wa = cnt_reg[5:0]; st_wd = value;
        lv_we = 1'b0; lv_wa = '0; lv_wd = '0;
        sm_we = 1'b0; sm_wd = '0;
        pa_we = 1'b0; pa_wa = '0; pa_wd = '0;
        ch_we = 1'b0; ch_wa = '0; ch_wd = '0;
        bg_we = 1'b0; bg_wa = '0; bg_wd = '0;
        st_ra = '0; lv_ra = '0; pa_ra = '0; ch_ra = '0; bg_ra = '0;

        case (cmd.op)
            OP_LOAD:
            begin
                if (cnt_reg < 7'(MAX_ELEMENTS))
                begin
                    st_we    = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                end
                else
                begin
                    drop_next = 1'b1;
                end
            end
            OP_INIT:
            begin
                lvl_next       = '0;
                lv_n_next[0]   = cnt_reg;
                lv_off_next[0] = '0;
                i_next         = '0;
            end
            OP_FILL:
            begin
                lv_we  = 1'b1;
                lv_wa  = i_reg;
                lv_wd  = i_reg[5:0];
                i_next = i_inc;
            end
            OP_DCHK:
            begin
                lv_n_next[lvl_inc]   = cur_n >> 1;
                lv_off_next[lvl_inc] = 7'(cur_off + cur_n);
                m_next               = cur_n >> 1;
                i_next               = '0;
            end
            OP_DRA:
            begin
                lv_ra = 7'(cur_off + {i_reg[5:0], 1'b0});
            end
            OP_DRB:
            begin
                a_next = lv_rd_reg;
                lv_ra  = 7'(cur_off + {i_reg[5:0], 1'b0} + 7'd1);
            end
            OP_DKA:
            begin
                b_next = lv_rd_reg;
                st_ra  = a_reg;
            end
            OP_DKB:
            begin
                ka_next = st_rd_reg;
                st_ra   = b_reg;
            end
            OP_DCMP:
            begin
                // second of a pair counts as larger on equal keys
                cmp_next = cmp_inc;
                lv_we    = 1'b1;
                sm_we    = 1'b1;
                lv_wa    = 7'(nxt_off + i_reg);
                lv_wd    = b_lt_a ? a_reg : b_reg;
                sm_wd    = b_lt_a ? b_reg : a_reg;
                i_next   = i_inc;
            end
            OP_LINC:
            begin
                lvl_next = lvl_inc;
            end
            OP_UINIT:
            begin
                lv_ra = cur_off;
            end
            OP_UBASE:
            begin
                ch_we = 1'b1;
                ch_wa = '0;
                ch_wd = lv_rd_reg;
            end
            OP_ULVL:
            begin
                m_next = nxt_n;
                i_next = '0;
            end
            OP_PRD:
            begin
                lv_ra = 7'(nxt_off + i_reg);
            end
            OP_PWR:
            begin
                pa_we  = 1'b1;
                pa_wa  = lv_rd_reg;
                pa_wd  = sm_rd_reg;
                i_next = (i_inc == m_reg) ? 7'd0 : i_inc;
            end
            OP_CRD:
            begin
                ch_ra = i_reg[5:0];
            end
            OP_CWR:
            begin
                bg_we  = 1'b1;
                bg_wa  = i_reg[5:0];
                bg_wd  = ch_rd_reg;
                i_next = (i_inc == m_reg) ? 7'd0 : i_inc;
            end
            OP_SRD:
            begin
                bg_ra = i_reg[5:0];
            end
            OP_SWR:
            begin
                ch_we  = 1'b1;
                ch_wa  = i_inc[5:0];
                ch_wd  = bg_rd_reg;
                i_next = (i_inc == m_reg) ? 7'd0 : i_inc;
            end
            OP_HRB:
            begin
                bg_ra = '0;
            end
            OP_HRP:
            begin
                pa_ra = bg_rd_reg;
            end
            OP_HWR:
            begin
                ch_we     = 1'b1;
                ch_wa     = '0;
                ch_wd     = pa_rd_reg;
                len_next  = m_reg + 7'd1;
                pend_next = m_reg + {6'd0, cur_n[0]};
                prev_next = 8'd1;
                cur_next  = 8'd3;
            end
            OP_JMIN:
            begin
                j_next = (cur_reg < {1'b0, pend_reg}) ? cur_reg[6:0] : pend_reg;
            end
            OP_JADV:
            begin
                prev_next = cur_reg;
                cur_next  = 8'(cur_reg + {prev_reg[6:0], 1'b0});
            end
            OP_PRB:
            begin
                bg_ra = 6'(j_reg - 7'd1);
            end
            OP_PHOLD:
            begin
                psl_next = bg_rd_reg;
                pos_next = '0;
            end
            OP_LRD:
            begin
                ch_ra = pos_reg[5:0];
            end
            OP_LCHK:
            begin
                if (ch_rd_reg == psl_reg)
                begin
                    bound_next = pos_reg;
                end
                else
                begin
                    pos_next = pos_reg + 7'd1;
                end
            end
            OP_ERD:
            begin
                pa_ra = psl_reg;
            end
            OP_EWR:
            begin
                elem_next = pa_rd_reg;
            end
            OP_ORD:
            begin
                lv_ra = 7'(cur_off + cur_n - 7'd1);
            end
            OP_OWR:
            begin
                elem_next  = lv_rd_reg;
                bound_next = len_reg;
            end
            OP_KRD:
            begin
                st_ra   = elem_reg;
                lo_next = '0;
                hi_next = bound_reg;
            end
            OP_KWR:
            begin
                ka_next = st_rd_reg;
            end
            OP_BMID:
            begin
                mid_next = mid_c;
                ch_ra    = mid_c[5:0];
            end
            OP_BRS:
            begin
                st_ra = ch_rd_reg;
            end
            OP_BCMP:
            begin
                // equal keys send the new element to the right
                cmp_next = cmp_inc;
                if (e_lt_c)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 7'd1;
                end
            end
            OP_SINIT:
            begin
                k_next = len_reg;
            end
            OP_SRDK:
            begin
                ch_ra = 6'(k_reg - 7'd1);
            end
            OP_SHW:
            begin
                ch_we  = 1'b1;
                ch_wa  = k_reg[5:0];
                ch_wd  = ch_rd_reg;
                k_next = k_reg - 7'd1;
            end
            OP_INS:
            begin
                ch_we    = 1'b1;
                ch_wa    = lo_reg[5:0];
                ch_wd    = elem_reg;
                len_next = len_reg + 7'd1;
                j_next   = j_reg - 7'd1;
            end
            OP_LDEC:
            begin
                lvl_next = lvl_reg - 3'd1;
            end
            OP_OINIT:
            begin
                i_next = '0;
            end
            OP_ORC:
            begin
                ch_ra = i_reg[5:0];
            end
            OP_ORS:
            begin
                st_ra = ch_rd_reg;
            end
            OP_OLD:
            begin
                sv_next   = st_rd_reg;
                cv_next   = cmp_reg;
                ov_next   = drop_reg;
                last_next = i_inc == cnt_reg;
            end
            OP_ONXT:
            begin
                i_next = i_inc;
            end
            OP_CLR:
            begin
                cnt_next  = '0;
                cmp_next  = '0;
                drop_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            cmp_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            cmp_reg  <= cmp_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        lv_n_reg   <= lv_n_next;
        lv_off_reg <= lv_off_next;
        i_reg      <= i_next;
        m_reg      <= m_next;
        len_reg    <= len_next;
        pend_reg   <= pend_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        j_reg      <= j_next;
        pos_reg    <= pos_next;
        bound_reg  <= bound_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        psl_reg    <= psl_next;
        elem_reg   <= elem_next;
        ka_reg     <= ka_next;
        sv_reg     <= sv_next;
        cv_reg     <= cv_next;
        ov_reg     <= ov_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        st_rd_reg <= st_mem[st_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lv_we)
        begin
            lv_mem[lv_wa] <= lv_wd;
        end
        lv_rd_reg <= lv_mem[lv_ra];
    end

    // pair losers share the level list addressing
    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sm_mem[lv_wa] <= sm_wd;
        end
        sm_rd_reg <= sm_mem[lv_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pa_we)
        begin
            pa_mem[pa_wa] <= pa_wd;
        end
        pa_rd_reg <= pa_mem[pa_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[ch_wa] <= ch_wd;
        end
        ch_rd_reg <= ch_mem[ch_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bg_we)
        begin
            bg_mem[bg_wa] <= bg_wd;
        end
        bg_rd_reg <= bg_mem[bg_ra];
    end

    assign sorted_value = sv_reg;
    assign comparisons  = cv_reg;
    assign overflowed   = ov_reg;
    assign last_result  = last_reg;

endmodule

// ----- rtl/merge_insertion_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_insertion_sorter
// merge-insertion sort of a loaded set of signed 32-bit values
// ----------------------------------------------------------------------------
// usage
//   item channel: one value per transfer, loaded at one transfer per cycle
//   while the block is loading; final_item closes the set and starts the sort
//   up to 64 values are held, further values are dropped and flagged
//   the sort first pairs and compares values level by level, then inserts
//   pending values by binary search and shifts the chain entries above each
//   insertion point up by one place
//   result channel: values leave in ascending order, each carrying the total
//   comparison count, the drop flag and a last marker on the final value
//   the payload holds while result_stall is high, and item_stall stays
//   high until the set is out
//   after the last transfer the count, comparison counter and drop flag clear
//   reset returns the block to loading with an empty set; memories keep
//   their contents, which are only read after being written
// ----------------------------------------------------------------------------
module merge_insertion_sorter
    import mis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] value,
    input  logic               final_item,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] sorted_value,
    output logic [8:0]         comparisons,
    output logic               overflowed,
    output logic               last_result
);

    cmd_t    cmd;
    status_t sts;

    // sequencer: owns handshakes, one datapath op per cycle unless stalled
    mis_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .final_item   (final_item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath: element store, per-level lists, chain and comparator
    mis_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .sorted_value (sorted_value),
        .comparisons  (comparisons),
        .overflowed   (overflowed),
        .last_result  (last_result)
    );

endmodule
